// ===== hw/rtl/lmsfg_pkg.sv =====
// shared constants and the built-in 8x8 font for the led matrix scroll frame generator
// no dependencies; imported by led_matrix_scroll_frame_generator, lmsfg_scroll_checker and tb_top
package lmsfg_pkg;

    localparam int CHAR_W   = 8;
    localparam int GLYPH_W  = 5;
    localparam int WORD64_W = 64;
    localparam int ROW_W    = 8;
    localparam int ROWA_W   = 4;
    localparam int FRAME_W  = 3;
    localparam int PADDR_W  = 4;

    localparam logic [CHAR_W-1:0]  CHAR_END     = 8'd0;
    localparam logic [CHAR_W-1:0]  CHAR_A       = 8'd65;
    localparam logic [CHAR_W-1:0]  CHAR_Z       = 8'd90;
    localparam logic [GLYPH_W-1:0] BLANK_GLYPH  = 5'd26;
    localparam logic [GLYPH_W-1:0] Y_GLYPH      = 5'd24;
    localparam logic [FRAME_W-1:0] LAST_FRAME   = 3'd6;
    localparam logic [FRAME_W-1:0] LAST_ROW     = 3'd7;
    localparam logic [FRAME_W-1:0] TOP_SHIFT    = 3'd7;

    // register index decoded from paddr bit 3 (8-byte register slots)
    localparam logic REG_GLYPH_Y = 1'b0;

    typedef logic [WORD64_W-1:0] glyph_word_t;

    // font rom; the y glyph and blank come out as zero here
    function automatic glyph_word_t font_word(input logic [GLYPH_W-1:0] idx);
        glyph_word_t w;
        case (idx)
            5'd0:    w = 64'h2222223e22221c00;
            5'd1:    w = 64'h1e22221e22221e00;
            5'd2:    w = 64'h3804020202043800;
            5'd3:    w = 64'h0e12222222120e00;
            5'd4:    w = 64'h3e02021e02023e00;
            5'd5:    w = 64'h0202021e02023e00;
            5'd6:    w = 64'h0c2a3a0202241800;
            5'd7:    w = 64'h2222223e22222200;
            5'd8:    w = 64'h3e08080808083e00;
            5'd9:    w = 64'h1e12101010103e00;
            5'd10:   w = 64'h22120a060a122200;
            5'd11:   w = 64'h3e22020202020200;
            5'd12:   w = 64'h2222222a2a2a1400;
            5'd13:   w = 64'h2232322a26262200;
            5'd14:   w = 64'h1c22222222221c00;
            5'd15:   w = 64'h0202021e22221e00;
            5'd16:   w = 64'h2c122a2622221c00;
            5'd17:   w = 64'h22120a1e22221e00;
            5'd18:   w = 64'h1c22201c02221c00;
            5'd19:   w = 64'h08080808082a3e00;
            5'd20:   w = 64'h1c22222222222200;
            5'd21:   w = 64'h0814222222222200;
            5'd22:   w = 64'h142a2a2a22222200;
            5'd23:   w = 64'h2222140808142200;
            5'd25:   w = 64'h3e02040810203e00;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] reverse8(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] r;
        for (int b = 0; b < ROW_W; b++) begin
            r[b] = v[ROW_W-1-b];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/led_matrix_scroll_frame_generator.sv =====
// top level: text character in, 8x8 scroll row writes out, apb register for the y glyph
// depends on lmsfg_pkg (font, constants, bit reverse)
//
// Every character that arrives while another is held, and the terminator (code 0) when a
// character is held, produces one transition of 56 row words (7 frames of 8 rows), issued
// at one word per cycle from a frame/row counter pair whenever the output is not stalled,
// and the block stays busy until the transition is done. The next character is
// accepted in the same cycle the final word of the current transition is issued, so
// transitions run back to back. A character that causes no output (any character that
// arrives with nothing held) is accepted without making the block busy. Output words sit in a
// result register, and the generator holds its place while a word waits to be taken.
// glyph_y may only be written while the block is idle.
module led_matrix_scroll_frame_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lmsfg_pkg::CHAR_W-1:0]   s_char_code,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lmsfg_pkg::ROWA_W-1:0]   m_row_address,
    output logic [lmsfg_pkg::ROW_W-1:0]    m_row_bits,
    output logic [lmsfg_pkg::FRAME_W-1:0]  m_frame_index,
    output logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmsfg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmsfg_pkg::WORD64_W-1:0] pwdata,
    output logic [lmsfg_pkg::WORD64_W-1:0] prdata,
    output logic                           pready
);
    import lmsfg_pkg::*;

    glyph_word_t        glyph_y_reg;
    logic               busy_reg, busy_next;
    logic [GLYPH_W-1:0] old_idx_reg, old_idx_next;
    logic [GLYPH_W-1:0] new_idx_reg, new_idx_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FRAME_W-1:0] row_reg, row_next;
    logic [GLYPH_W-1:0] prev_glyph_reg, prev_glyph_next;
    logic               prev_valid_reg, prev_valid_next;

    logic               m_valid_reg, m_valid_next;
    logic [ROWA_W-1:0]  m_row_address_reg;
    logic [ROW_W-1:0]   m_row_bits_reg;
    logic [FRAME_W-1:0] m_frame_index_reg;
    logic               m_last_reg;

    logic               out_free, gen_fire, last_word, s_fire, starts_xfer;
    logic [GLYPH_W-1:0] in_idx;
    glyph_word_t        old_word, new_word;
    logic [ROW_W-1:0]   old_row, new_row, mix_row;
    logic               cfg_write;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[3] == REG_GLYPH_Y) ? glyph_y_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_y_reg <= '0;
        end else if (cfg_write && paddr[3] == REG_GLYPH_Y) begin
            glyph_y_reg <= pwdata;
        end
    end

    // input side
    assign out_free  = !m_valid_reg || m_ready;
    assign gen_fire  = busy_reg && out_free;
    assign last_word = (frame_reg == LAST_FRAME) && (row_reg == LAST_ROW);
    assign s_ready   = !busy_reg || (gen_fire && last_word);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (s_char_code inside {[CHAR_A:CHAR_Z]}) begin
            in_idx = GLYPH_W'(s_char_code - CHAR_A);
        end else begin
            in_idx = BLANK_GLYPH;
        end
    end

    assign starts_xfer = s_fire && prev_valid_reg;

    // row word generation
    assign old_word = (old_idx_reg == Y_GLYPH) ? glyph_y_reg : font_word(old_idx_reg);
    assign new_word = (new_idx_reg == Y_GLYPH) ? glyph_y_reg : font_word(new_idx_reg);
    assign old_row  = old_word[ROW_W*row_reg +: ROW_W];
    assign new_row  = new_word[ROW_W*row_reg +: ROW_W];
    assign mix_row  = (old_row >> frame_reg) | (new_row << (TOP_SHIFT - frame_reg));

    always_comb begin
        busy_next       = busy_reg;
        old_idx_next    = old_idx_reg;
        new_idx_next    = new_idx_reg;
        frame_next      = frame_reg;
        row_next        = row_reg;
        prev_glyph_next = prev_glyph_reg;
        prev_valid_next = prev_valid_reg;
        m_valid_next    = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (gen_fire) begin
            m_valid_next = 1'b1;
            if (row_reg == LAST_ROW) begin
                row_next   = '0;
                frame_next = frame_reg + 3'd1;
            end else begin
                row_next = row_reg + 3'd1;
            end
            if (last_word) begin
                busy_next = 1'b0;
            end
        end

        if (s_fire) begin
            if (s_char_code == CHAR_END) begin
                if (prev_valid_reg) begin
                    old_idx_next    = prev_glyph_reg;
                    new_idx_next    = BLANK_GLYPH;
                    prev_valid_next = 1'b0;
                    prev_glyph_next = '0;
                end
            end else begin
                if (prev_valid_reg) begin
                    old_idx_next = prev_glyph_reg;
                    new_idx_next = in_idx;
                end
                prev_glyph_next = in_idx;
                prev_valid_next = 1'b1;
            end
            if (starts_xfer) begin
                busy_next  = 1'b1;
                frame_next = '0;
                row_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            frame_reg      <= '0;
            row_reg        <= '0;
            prev_glyph_reg <= '0;
            prev_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            frame_reg      <= frame_next;
            row_reg        <= row_next;
            prev_glyph_reg <= prev_glyph_next;
            prev_valid_reg <= prev_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_idx_reg <= old_idx_next;
        new_idx_reg <= new_idx_next;
        if (gen_fire) begin
            m_row_address_reg <= {1'b0, row_reg} + 4'd1;
            m_row_bits_reg    <= reverse8(mix_row);
            m_frame_index_reg <= frame_reg;
            m_last_reg        <= last_word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row_address = m_row_address_reg;
    assign m_row_bits    = m_row_bits_reg;
    assign m_frame_index = m_frame_index_reg;
    assign m_last        = m_last_reg;

    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> frame_reg <= LAST_FRAME)
        else $error("frame counter out of range");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_row_address_reg == 4'd8 &&
                                      m_frame_index_reg == LAST_FRAME)
        else $error("last flag off the final row of the final frame");

    a_ready_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && s_ready |-> gen_fire && last_word)
        else $error("input taken in the middle of a transition");

    a_char_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_char_code != CHAR_END |=> prev_valid_reg)
        else $error("character not held after acceptance");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_char_code == CHAR_END |=> !prev_valid_reg && prev_glyph_reg == '0 ||
                                              $past(!prev_valid_reg))
        else $error("terminator did not clear the held glyph");

endmodule

// ===== tb/lmsfg_scroll_checker.sv =====
`timescale 1ns / 100ps
// checker for the led matrix scroll frame generator: follows the apb register and the text
// channel, builds the expected scroll row words and compares them with the result channel
// depends on lmsfg_pkg for widths and character codes
module lmsfg_scroll_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [lmsfg_pkg::CHAR_W-1:0]   s_char_code,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [lmsfg_pkg::ROWA_W-1:0]   m_row_address,
    input  logic [lmsfg_pkg::ROW_W-1:0]    m_row_bits,
    input  logic [lmsfg_pkg::FRAME_W-1:0]  m_frame_index,
    input  logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmsfg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmsfg_pkg::WORD64_W-1:0] pwdata,
    input  logic [lmsfg_pkg::WORD64_W-1:0] prdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             words_due
);
    import lmsfg_pkg::*;

    typedef struct packed {
        logic [ROWA_W-1:0]  row_address;
        logic [ROW_W-1:0]   row_bits;
        logic [FRAME_W-1:0] frame_index;
        logic               last;
    } row_word_t;

    row_word_t            row_q[$];
    logic [WORD64_W-1:0]  y_bitmap;
    logic [GLYPH_W-1:0]   held_glyph;
    logic                 held_valid;

    function automatic logic [WORD64_W-1:0] glyph_bitmap(input logic [GLYPH_W-1:0] idx,
                                                         input logic [WORD64_W-1:0] y_word);
        if (idx == Y_GLYPH) begin
            return y_word;
        end
        case (idx)
            5'd0:    return 64'h2222223e22221c00;
            5'd1:    return 64'h1e22221e22221e00;
            5'd2:    return 64'h3804020202043800;
            5'd3:    return 64'h0e12222222120e00;
            5'd4:    return 64'h3e02021e02023e00;
            5'd5:    return 64'h0202021e02023e00;
            5'd6:    return 64'h0c2a3a0202241800;
            5'd7:    return 64'h2222223e22222200;
            5'd8:    return 64'h3e08080808083e00;
            5'd9:    return 64'h1e12101010103e00;
            5'd10:   return 64'h22120a060a122200;
            5'd11:   return 64'h3e22020202020200;
            5'd12:   return 64'h2222222a2a2a1400;
            5'd13:   return 64'h2232322a26262200;
            5'd14:   return 64'h1c22222222221c00;
            5'd15:   return 64'h0202021e22221e00;
            5'd16:   return 64'h2c122a2622221c00;
            5'd17:   return 64'h22120a1e22221e00;
            5'd18:   return 64'h1c22201c02221c00;
            5'd19:   return 64'h08080808082a3e00;
            5'd20:   return 64'h1c22222222222200;
            5'd21:   return 64'h0814222222222200;
            5'd22:   return 64'h142a2a2a22222200;
            5'd23:   return 64'h2222140808142200;
            5'd25:   return 64'h3e02040810203e00;
            default: return '0;
        endcase
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = c - CHAR_A;
        if (c >= CHAR_A && c <= CHAR_Z) begin
            return d[GLYPH_W-1:0];
        end
        return BLANK_GLYPH;
    endfunction

    // 7 frames of 8 rows sliding from the old glyph to the new one
    task automatic queue_transition(input logic [GLYPH_W-1:0] from_g,
                                    input logic [GLYPH_W-1:0] to_g);
        logic [WORD64_W-1:0] ow;
        logic [WORD64_W-1:0] nw;
        logic [15:0]         mix;
        row_word_t           w;
        ow = glyph_bitmap(from_g, y_bitmap);
        nw = glyph_bitmap(to_g, y_bitmap);
        for (int f = 0; f <= LAST_FRAME; f++) begin
            for (int n = 0; n <= LAST_ROW; n++) begin
                mix = ({8'h00, ow[8*n +: 8]} >> f) | ({8'h00, nw[8*n +: 8]} << (TOP_SHIFT - f));
                for (int b = 0; b < ROW_W; b++) begin
                    w.row_bits[b] = mix[ROW_W-1-b];
                end
                w.row_address = ROWA_W'(n + 1);
                w.frame_index = FRAME_W'(f);
                w.last        = (f == LAST_FRAME) && (n == LAST_ROW);
                row_q.push_back(w);
            end
        end
    endtask

    always @(posedge aclk) begin : track
        row_word_t          got;
        row_word_t          want;
        logic [GLYPH_W-1:0] g;
        if (!aresetn) begin
            row_q.delete();
            y_bitmap   = '0;
            held_glyph = '0;
            held_valid = 1'b0;
            fail_count = 0;
            words_due  <= 0;
        end else begin
            // results first: a word taken now never belongs to a character taken now
            if (m_valid && m_ready) begin
                got = {m_row_address, m_row_bits, m_frame_index, m_last};
                if (row_q.size() == 0) begin
                    $error("unexpected row word: row_address %0d row_bits %02h %s %0d last %0b",
                           got.row_address, got.row_bits, "frame_index",
                           got.frame_index, got.last);
                    fail_count++;
                end else begin
                    want = row_q.pop_front();
                    if (got.row_address !== want.row_address) begin
                        $error("row_address expected %0d got %0d",
                               want.row_address, got.row_address);
                        fail_count++;
                    end
                    if (got.row_bits !== want.row_bits) begin
                        $error("row_bits expected %02h got %02h", want.row_bits, got.row_bits);
                        fail_count++;
                    end
                    if (got.frame_index !== want.frame_index) begin
                        $error("frame_index expected %0d got %0d",
                               want.frame_index, got.frame_index);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last expected %0b got %0b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pready && paddr[PADDR_W-1:3] == REG_GLYPH_Y) begin
                if (pwrite) begin
                    y_bitmap = pwdata;
                end else if (prdata !== y_bitmap) begin
                    $error("prdata expected %016h got %016h", y_bitmap, prdata);
                    fail_count++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_char_code == CHAR_END) begin
                    if (held_valid) begin
                        queue_transition(held_glyph, BLANK_GLYPH);
                        held_valid = 1'b0;
                        held_glyph = '0;
                    end
                end else begin
                    g = glyph_of(s_char_code);
                    if (held_valid) begin
                        queue_transition(held_glyph, g);
                    end
                    held_glyph = g;
                    held_valid = 1'b1;
                end
            end
            words_due <= row_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top of the scroll frame generator testbench: clock, reset, text and apb stimulus, verdict
// depends on lmsfg_pkg, led_matrix_scroll_frame_generator and lmsfg_scroll_checker
module tb_top;
    import lmsfg_pkg::*;

    localparam int                 QUIET_LIMIT  = 5000;
    localparam int                 PHASE_CHARS  = 85;
    localparam logic [PADDR_W-1:0] ADDR_GLYPH_Y = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED  = 4'h8;
    localparam logic [CHAR_W-1:0]  CHAR_B       = CHAR_A + 8'd1;
    localparam logic [CHAR_W-1:0]  CHAR_M       = CHAR_A + 8'd12;
    localparam logic [CHAR_W-1:0]  CHAR_Y       = CHAR_A + 8'(Y_GLYPH);

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_char_code;
    logic                  m_valid;
    logic                  m_ready;
    logic [ROWA_W-1:0]     m_row_address;
    logic [ROW_W-1:0]      m_row_bits;
    logic [FRAME_W-1:0]    m_frame_index;
    logic                  m_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [WORD64_W-1:0]   pwdata;
    logic [WORD64_W-1:0]   prdata;
    logic                  pready;
    int                    fail_count;
    int                    words_due;
    int                    send_calm;
    logic                  text_held;

    led_matrix_scroll_frame_generator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_address (m_row_address),
        .m_row_bits    (m_row_bits),
        .m_frame_index (m_frame_index),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lmsfg_scroll_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_address (m_row_address),
        .m_row_bits    (m_row_bits),
        .m_frame_index (m_frame_index),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .words_due     (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // result side: random stalls, calm stretches and two long hold-offs
    initial begin : row_sink
        int words;
        int stall_left;
        int calm;
        int holds;
        int r;
        words      = 0;
        stall_left = 0;
        calm       = 0;
        holds      = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                words++;
            end
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (holds < 2 && words >= (holds == 0 ? 3000 : 12000)) begin
                holds++;
                stall_left = $urandom_range(400, 600);
                m_ready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    calm = $urandom_range(50, 300);
                    m_ready <= 1'b1;
                end else if (r < 65) begin
                    m_ready <= 1'b1;
                end else if (r < 93) begin
                    stall_left = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(5, 40);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // returns right after the rising edge that takes the character, valid still high
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else if (r < 2) begin
            send_calm = $urandom_range(10, 40);
            gap = 0;
        end else if (r < 60) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(5, 30);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        text_held = (c != CHAR_END);
    endtask

    // stop offering and wait for the block to drain before touching the register
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [WORD64_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_glyph_y(input logic [WORD64_W-1:0] value);
        settle();
        apb_access(1'b1, ADDR_GLYPH_Y, value);
        apb_access(1'b0, ADDR_GLYPH_Y, '0);
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CHAR_W'($urandom_range(CHAR_A, CHAR_Z));
        end else if (r < 77) begin
            return CHAR_Y;
        end else if (r < 88) begin
            return CHAR_W'($urandom_range(1, 255));
        end
        return CHAR_END;
    endfunction

    initial begin : stimulus
        logic [WORD64_W-1:0] y_setting [4];
        logic [CHAR_W-1:0]   c;
        int                  counted;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        send_calm   = 0;
        text_held   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of glyph_y, then text with a blank y glyph
        apb_access(1'b0, ADDR_GLYPH_Y, '0);
        send_char(CHAR_END);
        send_char(CHAR_A);
        send_char(CHAR_Z);
        send_char(CHAR_Y);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(CHAR_END);
        send_char(CHAR_END);
        send_char(CHAR_M);
        send_char(CHAR_A - 8'd1);
        send_char(CHAR_Z + 8'd1);
        send_char(CHAR_B);
        send_char(CHAR_END);

        // all-ones y glyph; a write to the unused slot must not disturb it
        set_glyph_y('1);
        apb_access(1'b1, ADDR_UNUSED, 64'h0123456789abcdef);
        apb_access(1'b0, ADDR_GLYPH_Y, '0);
        send_char(CHAR_Y);
        send_char(CHAR_A);
        send_char(CHAR_Y);
        send_char(CHAR_Y);
        send_char(8'h80);
        send_char(CHAR_END);

        y_setting[0] = 64'h8000000000000001;
        y_setting[1] = {$urandom, $urandom};
        y_setting[2] = '0;
        y_setting[3] = {$urandom, $urandom};
        for (int p = 0; p < 4; p++) begin
            set_glyph_y(y_setting[p]);
            counted = 0;
            while (counted < PHASE_CHARS) begin
                c = random_char();
                // a terminator with nothing held is ignored and does not count
                if (c != CHAR_END || text_held) begin
                    counted++;
                end
                send_char(c);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== led_matrix_scroll_frame_generator.f =====
hw/rtl/lmsfg_pkg.sv
hw/rtl/led_matrix_scroll_frame_generator.sv
tb/lmsfg_scroll_checker.sv
tb/tb_top.sv
